// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int CELL_W   = 14;
    localparam int COUNT_W  = 15;
    localparam int WORD_W   = 16;
    localparam int KIND_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int NUM_SLOTS  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 3'd0,
        KIND_FILL   = 3'd1,
        KIND_COPY   = 3'd2,
        KIND_START  = 3'd3,
        KIND_CURSOR = 3'd4
    } t_kind;

    localparam int SLOT_COPY   = 0;
    localparam int SLOT_FILL   = 1;
    localparam int SLOT_START  = 2;
    localparam int SLOT_WRITE  = 3;
    localparam int SLOT_CURSOR = 4;

    localparam logic [NUM_SLOTS-1:0] MASK_CURSOR = NUM_SLOTS'(1) << SLOT_CURSOR;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HW_SCROLL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd4;

    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;

    localparam logic [WORD_W-1:0] ERASE_WORD = 16'h0720;

    typedef struct packed {
        logic [7:0]        columns;
        logic [5:0]        rows;
        logic [7:0]        attribute;
        logic              hw_scroll;
        logic [14:0]       window_cells;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        col;
        logic [5:0]        row;
        logic [CELL_W-1:0] cell_addr;
        logic [CELL_W-1:0] start;
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [CELL_W-1:0]  dest_cell;
        logic [CELL_W-1:0]  src_cell;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  cell_word;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        t_cmd [NUM_SLOTS-1:0] cmds;
        t_state               next;
    } t_step;

endpackage

// ===== hw/rtl/tcw_ifs.sv =====
interface tcw_char_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tcw_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::KIND_W-1:0]   kind;
    logic [tcw_pkg::CELL_W-1:0]   dest_cell;
    logic [tcw_pkg::CELL_W-1:0]   src_cell;
    logic [tcw_pkg::COUNT_W-1:0]  count;
    logic [tcw_pkg::WORD_W-1:0]   cell_word;
    logic                         last;
    modport source (output valid, output kind, output dest_cell, output src_cell,
                    output count, output cell_word, output last, input ready);
    modport sink   (input valid, input kind, input dest_cell, input src_cell,
                    input count, input cell_word, input last, output ready);
endinterface

interface tcw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::CFG_IDX_W-1:0]  index;
    logic [tcw_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tcw_step.sv =====
module tcw_step #(
    parameter int WINDOW_MAX_CELLS = 16384
) (
    input  logic [tcw_pkg::CHAR_W-1:0] i_char,
    input  tcw_pkg::t_state            i_state,
    input  tcw_pkg::t_cfg              i_cfg,
    output tcw_pkg::t_step             o_step
);

    localparam logic [16:0] WMAX = 17'(WINDOW_MAX_CELLS);

    logic [7:0]                  c;
    logic [5:0]                  r;
    logic [5:0]                  rm1;
    logic [tcw_pkg::CELL_W-1:0]  rc_less;
    logic [tcw_pkg::CELL_W-1:0]  rc_full;
    logic [14:0]                 wc;
    logic [16:0]                 w;
    logic [7:0]                  col;
    logic [5:0]                  row;
    logic [tcw_pkg::CELL_W-1:0]  cell_addr;
    logic [tcw_pkg::CELL_W-1:0]  start;
    logic                        printable;
    logic                        do_lf;
    logic [3:0]                  stepn;
    logic [8:0]                  colw;
    logic [14:0]                 ns;
    logic [15:0]                 endv;
    logic [14:0]                 fill_at;

    always_comb begin
        c       = (i_cfg.columns == '0) ? 8'd1 : i_cfg.columns;
        r       = (i_cfg.rows == '0) ? 6'd1 : i_cfg.rows;
        rm1     = r - 6'd1;
        rc_less = 14'({8'd0, rm1} * {6'd0, c});
        rc_full = rc_less + {6'd0, c};
        wc      = (i_cfg.window_cells == '0) ? 15'd1 : i_cfg.window_cells;
        w       = ({2'b00, wc} > WMAX) ? WMAX : {2'b00, wc};

        col       = i_state.col;
        row       = i_state.row;
        cell_addr = i_state.cell_addr;
        start     = i_state.start;
        do_lf   = 1'b0;
        stepn   = '0;
        colw    = '0;
        ns      = '0;
        endv    = '0;
        fill_at = '0;
        o_step  = '0;

        printable = i_char inside {[tcw_pkg::CH_PRINT_LO:tcw_pkg::CH_PRINT_HI]};

        if (printable) begin
            if (col >= c) begin
                col       = col - c;
                cell_addr = cell_addr - {6'd0, c};
                do_lf     = 1'b1;
            end
        end else begin
            case (i_char)
                tcw_pkg::CH_BS: begin
                    if (col != '0) begin
                        col       = col - 8'd1;
                        cell_addr = cell_addr - 14'd1;
                    end
                end
                tcw_pkg::CH_TAB: begin
                    stepn     = 4'd8 - {1'b0, col[2:0]};
                    colw      = {1'b0, col} + {5'd0, stepn};
                    cell_addr = cell_addr + {10'd0, stepn};
                    if (colw > {1'b0, c}) begin
                        colw      = colw - {1'b0, c};
                        cell_addr = cell_addr - {6'd0, c};
                        do_lf     = 1'b1;
                    end
                    col = colw[7:0];
                end
                tcw_pkg::CH_LF, tcw_pkg::CH_VT, tcw_pkg::CH_FF: begin
                    do_lf = 1'b1;
                end
                tcw_pkg::CH_CR: begin
                    cell_addr = cell_addr - {6'd0, col};
                    col       = '0;
                end
                default: begin
                end
            endcase
        end

        if (do_lf) begin
            if ({1'b0, row} + 7'd1 < {1'b0, r}) begin
                row       = row + 6'd1;
                cell_addr = cell_addr + {6'd0, c};
            end else if (i_cfg.hw_scroll) begin
                ns        = {1'b0, start} + {7'd0, c};
                endv      = {1'b0, ns} + {2'b00, rc_full};
                cell_addr = cell_addr + {6'd0, c};
                o_step.mask[tcw_pkg::SLOT_FILL]            = 1'b1;
                o_step.cmds[tcw_pkg::SLOT_FILL].kind       = tcw_pkg::KIND_FILL;
                o_step.cmds[tcw_pkg::SLOT_FILL].count      = {7'd0, c};
                o_step.cmds[tcw_pkg::SLOT_FILL].cell_word  = tcw_pkg::ERASE_WORD;
                if ({1'b0, endv} > w) begin
                    o_step.mask[tcw_pkg::SLOT_COPY]           = 1'b1;
                    o_step.cmds[tcw_pkg::SLOT_COPY].kind      = tcw_pkg::KIND_COPY;
                    o_step.cmds[tcw_pkg::SLOT_COPY].src_cell  = ns[13:0];
                    o_step.cmds[tcw_pkg::SLOT_COPY].count     = {1'b0, rc_less};
                    o_step.cmds[tcw_pkg::SLOT_FILL].dest_cell = rc_less;
                    cell_addr = cell_addr - ns[13:0];
                    start     = '0;
                end else begin
                    fill_at = ns + {1'b0, rc_less};
                    o_step.cmds[tcw_pkg::SLOT_FILL].dest_cell = fill_at[13:0];
                    start = ns[13:0];
                end
                o_step.mask[tcw_pkg::SLOT_START]           = 1'b1;
                o_step.cmds[tcw_pkg::SLOT_START].kind      = tcw_pkg::KIND_START;
                o_step.cmds[tcw_pkg::SLOT_START].dest_cell = start;
            end else begin
                o_step.mask[tcw_pkg::SLOT_COPY]            = 1'b1;
                o_step.cmds[tcw_pkg::SLOT_COPY].kind       = tcw_pkg::KIND_COPY;
                o_step.cmds[tcw_pkg::SLOT_COPY].dest_cell  = start;
                o_step.cmds[tcw_pkg::SLOT_COPY].src_cell   = start + {6'd0, c};
                o_step.cmds[tcw_pkg::SLOT_COPY].count      = {1'b0, rc_less};
                o_step.mask[tcw_pkg::SLOT_FILL]            = 1'b1;
                o_step.cmds[tcw_pkg::SLOT_FILL].kind       = tcw_pkg::KIND_FILL;
                o_step.cmds[tcw_pkg::SLOT_FILL].dest_cell  = start + rc_less;
                o_step.cmds[tcw_pkg::SLOT_FILL].count      = {7'd0, c};
                o_step.cmds[tcw_pkg::SLOT_FILL].cell_word  = tcw_pkg::ERASE_WORD;
            end
        end

        if (printable) begin
            o_step.mask[tcw_pkg::SLOT_WRITE]           = 1'b1;
            o_step.cmds[tcw_pkg::SLOT_WRITE].kind      = tcw_pkg::KIND_WRITE;
            o_step.cmds[tcw_pkg::SLOT_WRITE].dest_cell = cell_addr;
            o_step.cmds[tcw_pkg::SLOT_WRITE].cell_word = {i_cfg.attribute, i_char};
            cell_addr = cell_addr + 14'd1;
            col       = col + 8'd1;
        end

        o_step.mask[tcw_pkg::SLOT_CURSOR]           = 1'b1;
        o_step.cmds[tcw_pkg::SLOT_CURSOR].kind      = tcw_pkg::KIND_CURSOR;
        o_step.cmds[tcw_pkg::SLOT_CURSOR].dest_cell = cell_addr;
        o_step.cmds[tcw_pkg::SLOT_CURSOR].last      = 1'b1;

        o_step.next.col       = col;
        o_step.next.row       = row;
        o_step.next.cell_addr = cell_addr;
        o_step.next.start     = start;
    end

endmodule

// ===== hw/rtl/text_console_char_writer_top.sv =====
// Flow: a character transfer is registered, then decoded into its command list, which is
// registered once the previous list has been taken; commands are offered from that register.
// Throughput: one command per cycle while o_cmd.ready is high; a character causes 1 to 5
// commands, which leave one at a time through the single command output port.
// Reset: synchronous, active low; cursor and display start go to cell 0 and the
// registers take columns 80, rows 25, attribute 7, hardware scroll on, window 16384.
module text_console_char_writer_top #(
    parameter int WINDOW_MAX_CELLS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_char_if.sink    i_char,
    tcw_cfg_if.sink     i_cfg,
    tcw_cmd_if.source   o_cmd
);

    logic                              r_in_valid;
    logic [tcw_pkg::CHAR_W-1:0]        r_char;
    tcw_pkg::t_state                   r_state;
    tcw_pkg::t_cfg                     r_cfg;
    logic [tcw_pkg::NUM_SLOTS-1:0]     r_mask;
    tcw_pkg::t_cmd [tcw_pkg::NUM_SLOTS-1:0] r_cmds;

    tcw_pkg::t_step                    w_step;
    logic                              w_load;
    logic                              w_in_xfer;
    logic                              w_out_xfer;
    logic [tcw_pkg::NUM_SLOTS-1:0]     w_pick;
    tcw_pkg::t_cmd                     w_out;

    tcw_step #(
        .WINDOW_MAX_CELLS(WINDOW_MAX_CELLS)
    ) u_step (
        .i_char  (r_char),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_step  (w_step)
    );

    assign w_out_xfer = o_cmd.valid && o_cmd.ready;
    assign w_load     = r_in_valid &&
                        ((r_mask == '0) || (o_cmd.ready && (r_mask == tcw_pkg::MASK_CURSOR)));
    assign i_char.ready = !r_in_valid || w_load;
    assign w_in_xfer  = i_char.valid && i_char.ready;
    assign i_cfg.ready = 1'b1;

    assign w_pick = r_mask & (~r_mask + tcw_pkg::NUM_SLOTS'(1));

    always_comb begin
        w_out = '0;
        for (int k = 0; k < tcw_pkg::NUM_SLOTS; k++) begin
            if (w_pick[k]) begin
                w_out = w_out | r_cmds[k];
            end
        end
    end

    assign o_cmd.valid     = (r_mask != '0);
    assign o_cmd.kind      = w_out.kind;
    assign o_cmd.dest_cell = w_out.dest_cell;
    assign o_cmd.src_cell  = w_out.src_cell;
    assign o_cmd.count     = w_out.count;
    assign o_cmd.cell_word = w_out.cell_word;
    assign o_cmd.last      = w_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_mask              <= '0;
            r_state             <= '0;
            r_cfg.columns       <= 8'd80;
            r_cfg.rows          <= 6'd25;
            r_cfg.attribute     <= 8'd7;
            r_cfg.hw_scroll     <= 1'b1;
            r_cfg.window_cells  <= 15'd16384;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end
            if (w_load) begin
                r_mask  <= w_step.mask;
                r_state <= w_step.next;
            end else if (w_out_xfer) begin
                r_mask <= r_mask & ~w_pick;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    tcw_pkg::REG_COLUMNS:   r_cfg.columns      <= i_cfg.data[7:0];
                    tcw_pkg::REG_ROWS:      r_cfg.rows         <= i_cfg.data[5:0];
                    tcw_pkg::REG_ATTRIBUTE: r_cfg.attribute    <= i_cfg.data[7:0];
                    tcw_pkg::REG_HW_SCROLL: r_cfg.hw_scroll    <= i_cfg.data[0];
                    tcw_pkg::REG_WINDOW:    r_cfg.window_cells <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_char <= i_char.char_code;
        end
        if (w_load) begin
            r_cmds <= w_step.cmds;
        end
    end

    a_cursor_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != '0) |-> r_mask[tcw_pkg::SLOT_CURSOR])
        else $error("command list lost its cursor update");

    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && o_cmd.last) |-> $onehot(r_mask))
        else $error("last command offered while others pend");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_cmd.valid && r_mask[tcw_pkg::SLOT_CURSOR]))
        else $error("decoded character produced no commands");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !o_cmd.last) |=> o_cmd.valid)
        else $error("command sequence broken before last");

endmodule
